[src/irclt_pkg.sv]
package irclt_pkg;

  // Field tag carried with each byte.
  typedef enum logic [2:0] {
    FK_NONE     = 3'd0,
    FK_PREFIX   = 3'd1,
    FK_COMMAND  = 3'd2,
    FK_MIDDLE   = 3'd3,
    FK_TRAILING = 3'd4
  } field_kind_e;

  // Command codes reported at line end.
  localparam logic [3:0] CMD_UNKNOWN = 4'd0;
  localparam logic [3:0] CMD_NUMERIC = 4'd1;
  localparam logic [3:0] CMD_KW_BASE = 4'd2;

  // Special octets.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  localparam int unsigned CMD_SLOTS = 7;
  localparam int unsigned NUM_KW    = 14;
  localparam logic [9:0]  NUM_SAT   = 10'd999;

  // Command bytes are shifted in at the low end, so a short command sits
  // right-justified with zeros above, exactly like a zero-extended string.
  localparam logic [8*CMD_SLOTS-1:0] KW_TEXT [NUM_KW] = '{
    "NICK", "QUIT", "JOIN", "PART", "MODE", "TOPIC", "INVITE",
    "KICK", "PRIVMSG", "NOTICE", "PING", "PONG", "ERROR", "WALLOPS"
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd6,
    4'd4, 4'd7, 4'd6, 4'd4, 4'd4, 4'd5, 4'd7
  };

  // One tagged result per byte.
  typedef struct packed {
    logic [7:0]  byte_out;
    field_kind_e field_kind;
    logic [3:0]  param_index;
    logic        field_start;
    logic        line_end;
    logic [3:0]  command_code;
    logic [9:0]  numeric_value;
    logic [3:0]  param_count;
  } result_t;

endpackage

[src/irc_line_tokenizer_core.sv]
// IRC line tokenizer: takes one received octet per request on the slave
// stream and returns one tagged result per octet on the master stream, in
// order, with the octet passed through. CR or LF closes a line; on the
// terminator of a non-empty line tlast is high and the command code
// (unknown, numeric, or one of the fourteen keywords), the numeric value
// (saturating at 999) and the parameter count are reported. NUL octets
// come out untagged and leave the parser state untouched. Throughput is
// one octet per clock: the parse of a byte is a single pass of logic
// between the input register and a two-entry output buffer, so
// back-to-back requests flow without bubbles while the sink takes them.
// An octet passes the input register, then the output buffer. A stalled
// sink fills the output buffer and then the input register before
// s_axis_tready_o drops. No configuration and no clearing pass after reset.
module irc_line_tokenizer_core #(
  parameter int unsigned MAX_PARAMS = 15  // 1..15 parameters kept per line
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] byte_in
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] byte_out, [11:8] param_index, [12] field_start,
  // [16:13] command_code, [26:17] numeric_value, [30:27] param_count, [31] zero
  output logic [31:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,  // [2:0] field_kind
  output logic        m_axis_tlast_o   // line_end
);
  import irclt_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       buf_ready;
  logic       fire;
  result_t    res;
  result_t    out_res;

  // a byte leaves the input register when the buffer has room
  assign fire            = in_valid_q && buf_ready;
  assign s_axis_tready_o = !in_valid_q || buf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) in_byte_q <= s_axis_tdata_i;
  end

  irclt_parser #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  irclt_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tdata_o = {1'b0, out_res.param_count, out_res.numeric_value,
                           out_res.command_code, out_res.field_start,
                           out_res.param_index, out_res.byte_out};
  assign m_axis_tuser_o = out_res.field_kind;
  assign m_axis_tlast_o = out_res.line_end;

endmodule

[src/irclt_parser.sv]
module irclt_parser #(
  parameter int unsigned MAX_PARAMS = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  output irclt_pkg::result_t res_o
);
  import irclt_pkg::*;

  typedef enum logic [2:0] {
    PH_LINE_START = 3'd0,
    PH_PREFIX     = 3'd1,
    PH_GAP_CMD    = 3'd2,
    PH_CMD        = 3'd3,
    PH_GAP_PARAM  = 3'd4,
    PH_MIDDLE     = 3'd5,
    PH_TRAILING   = 3'd6,
    PH_SKIP       = 3'd7
  } phase_e;

  localparam logic [3:0] MaxParams = 4'(MAX_PARAMS);
  localparam logic [3:0] CmdSlots  = 4'(CMD_SLOTS);

  phase_e                   phase_q, phase_d;
  logic                     nonempty_q, nonempty_d;
  logic [3:0]               params_q, params_d;
  logic [8*CMD_SLOTS-1:0]   chars_q, chars_d;
  logic [3:0]               len_q, len_d;
  logic [9:0]               acc_q, acc_d;
  logic                     numflag_q, numflag_d;
  logic                     running_q, running_d;

  logic        is_digit, is_term, is_sp, is_colon;
  logic [3:0]  cmd_code;
  logic [13:0] acc_next;
  logic        cmd_take;
  logic        run_v;

  assign is_digit = byte_i inside {[CHAR_0:CHAR_9]};
  assign is_term  = byte_i inside {CHAR_CR, CHAR_LF};
  assign is_sp    = (byte_i == CHAR_SPACE);
  assign is_colon = (byte_i == CHAR_COLON);
  // digit value is the low nibble of '0'..'9'
  assign acc_next = 14'(acc_q) * 14'd10 + 14'(byte_i[3:0]);

  // keyword match on the stored command
  always_comb begin
    cmd_code = CMD_UNKNOWN;
    if (numflag_q) begin
      cmd_code = CMD_NUMERIC;
    end else begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (len_q == KW_LEN[k] && chars_q == KW_TEXT[k]) begin
          cmd_code = CMD_KW_BASE + 4'(k);
        end
      end
    end
  end

  always_comb begin
    phase_d    = phase_q;
    nonempty_d = nonempty_q;
    params_d   = params_q;
    chars_d    = chars_q;
    len_d      = len_q;
    acc_d      = acc_q;
    numflag_d  = numflag_q;
    running_d  = running_q;
    cmd_take   = 1'b0;
    run_v      = running_q;

    res_o               = '0;
    res_o.byte_out      = byte_i;
    res_o.field_kind    = FK_NONE;

    if (is_term) begin
      if (nonempty_q) begin
        res_o.line_end      = 1'b1;
        res_o.command_code  = cmd_code;
        res_o.numeric_value = (cmd_code == CMD_NUMERIC) ? acc_q : 10'd0;
        res_o.param_count   = params_q;
      end
      phase_d    = PH_LINE_START;
      nonempty_d = 1'b0;
      params_d   = '0;
      chars_d    = '0;
      len_d      = '0;
      acc_d      = '0;
      numflag_d  = 1'b0;
      running_d  = 1'b0;
    end else if (byte_i != CHAR_NUL) begin
      nonempty_d = 1'b1;
      case (phase_q)
        PH_LINE_START: begin
          if (is_colon) begin
            phase_d           = PH_PREFIX;
            res_o.field_kind  = FK_PREFIX;
            res_o.field_start = 1'b1;
          end else if (!is_sp) begin
            cmd_take = 1'b1;
          end else begin
            phase_d = PH_GAP_CMD;
          end
        end
        PH_PREFIX: begin
          if (is_sp) phase_d = PH_GAP_CMD;
          else res_o.field_kind = FK_PREFIX;
        end
        PH_GAP_CMD: begin
          if (!is_sp) cmd_take = 1'b1;
        end
        PH_CMD: begin
          if (is_sp) begin
            phase_d = PH_GAP_PARAM;
          end else begin
            res_o.field_kind = FK_COMMAND;
            cmd_take         = 1'b1;
          end
        end
        PH_GAP_PARAM: begin
          if (!is_sp) begin
            if (params_q >= MaxParams) begin
              phase_d = PH_SKIP;
            end else begin
              phase_d           = is_colon ? PH_TRAILING : PH_MIDDLE;
              res_o.field_kind  = is_colon ? FK_TRAILING : FK_MIDDLE;
              res_o.field_start = 1'b1;
              res_o.param_index = params_q;
              params_d          = params_q + 4'd1;
            end
          end
        end
        PH_MIDDLE: begin
          if (is_sp) begin
            phase_d = PH_GAP_PARAM;
          end else begin
            res_o.field_kind  = FK_MIDDLE;
            res_o.param_index = params_q - 4'd1;
          end
        end
        PH_TRAILING: begin
          res_o.field_kind  = FK_TRAILING;
          res_o.param_index = params_q - 4'd1;
        end
        default: ;
      endcase

      if (cmd_take) begin
        // first command byte opens the field
        if (phase_q != PH_CMD) begin
          phase_d           = PH_CMD;
          res_o.field_kind  = FK_COMMAND;
          res_o.field_start = 1'b1;
        end
        if (len_q == 4'd0 && is_digit) begin
          numflag_d = 1'b1;
          run_v     = 1'b1;
        end
        if (run_v) begin
          if (is_digit) acc_d = (acc_next > 14'(NUM_SAT)) ? NUM_SAT : acc_next[9:0];
          else run_v = 1'b0;
        end
        running_d = run_v;
        if (len_q < CmdSlots) chars_d = {chars_q[8*CMD_SLOTS-9:0], byte_i};
        if (len_q <= CmdSlots) len_d = len_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LINE_START;
      nonempty_q <= 1'b0;
      params_q   <= '0;
      chars_q    <= '0;
      len_q      <= '0;
      acc_q      <= '0;
      numflag_q  <= 1'b0;
      running_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      nonempty_q <= nonempty_d;
      params_q   <= params_d;
      chars_q    <= chars_d;
      len_q      <= len_d;
      acc_q      <= acc_d;
      numflag_q  <= numflag_d;
      running_q  <= running_d;
    end
  end

  a_line_end_untagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.line_end |-> res_o.field_kind == FK_NONE && res_o.param_index == 4'd0)
    else $error("line end tagged as a field byte");

  a_start_has_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.field_start |-> res_o.field_kind != FK_NONE)
    else $error("field start on an untagged byte");

  a_params_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    params_q <= MaxParams)
    else $error("parameter count beyond limit");

  a_numeric_only_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> numflag_q)
    else $error("digit run without numeric command");

endmodule

[src/irclt_out_buf.sv]
module irclt_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  irclt_pkg::result_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               pop_ready_i,
  output irclt_pkg::result_t data_o
);
  import irclt_pkg::*;

  result_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into full output buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output buffer count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("output buffer pointers out of step");

endmodule
